// ----- sv/sorted_halves_merge_top_macros.svh -----
// Assertion macros used by the merge block checker.
`ifndef SORTED_HALVES_MERGE_TOP_MACROS_SVH
`define SORTED_HALVES_MERGE_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SHM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SHM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/shm_pkg.sv -----
// Shared constants, codes and types of the sorted-halves merge block.
`timescale 1ns / 1ps
`default_nettype none

package shm_pkg;

   // Capacity and widths
   localparam int MAX_ELEMS = 32;
   localparam int DATA_W    = 32;
   localparam int LEN_W     = 6;
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   localparam int ADDR_W    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int LEN_X_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int STATUS_W  = 2;

   localparam logic [LEN_W-1:0] LEFT_LEN_RESET = LEN_W'(4);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_MERGED     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_SORTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW   = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      S_LOAD,
      S_READ,
      S_CMP,
      S_SEND
   } state_type;

endpackage

`default_nettype wire

// ----- sv/shm_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module shm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]                           rd_data_a,
   output logic      [WIDTH-1:0]                           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write one entry, register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ----- sv/sorted_halves_merge_top.sv -----
// Sorted-halves merge: loads a list of signed values, checks that the two runs are
// sorted and streams out their stable merge (left element wins ties), or one status
// result (1 runs not sorted, 2 capacity overflow, overflow wins). While loading,
// req_stall is low and an element is taken whenever req_valid is high. After the
// element marked last, req_stall stays high until the final result is transferred:
// S_READ primes the element RAM read, then each merged element passes S_CMP (compare
// on the RAM's registered read ports) and S_SEND (output transfer, held on rsp_stall). A
// status result appears the cycle after the last element. csr_left_len may be written at any
// time the block is idle; the store needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_halves_merge_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration write
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [shm_pkg::LEN_W-1:0]             csr_left_len,
   // Element input
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [shm_pkg::DATA_W-1:0]     req_value,
   input  wire logic                                  req_last_in,
   // Result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [shm_pkg::DATA_W-1:0]          rsp_merged_value,
   output logic        [shm_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                       rsp_last_out
);

   import shm_pkg::*;

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      left_len_ff, left_len_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_W-1:0]     prev_ff, prev_in;
   logic                  broken_ff, broken_in;
   logic                  over_ff, over_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      split_ff, split_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  full;
   logic [CNT_W-1:0]      total_new;
   logic [LEN_X_W-1:0]    left_x;
   logic [LEN_X_W-1:0]    total_x;
   logic [LEN_X_W-1:0]    count_x;
   logic [CNT_W-1:0]      split_new;
   logic                  step_broken;
   logic                  over_new;
   logic                  broken_new;
   logic [DATA_W-1:0]     rd_a;
   logic [DATA_W-1:0]     rd_b;
   logic [DATA_W-1:0]     cmp_lo;
   logic [DATA_W-1:0]     cmp_hi;
   logic                  cmp_le;
   logic                  take_left;
   logic [CNT_W-1:0]      i_step;
   logic [CNT_W-1:0]      j_step;

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_LOAD);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // Element store
   shm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (req_xfer && !full),
      .wr_addr   (count_ff[ADDR_W-1:0]),
      .wr_data   (req_value),
      .rd_addr_a (i_ff[ADDR_W-1:0]),
      .rd_addr_b (j_ff[ADDR_W-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Shared signed compare: order check while loading, head compare while merging
   assign cmp_lo = (state_ff == S_LOAD) ? prev_ff : rd_a;
   assign cmp_hi = (state_ff == S_LOAD) ? req_value : rd_b;
   assign cmp_le = ($signed(cmp_lo) <= $signed(cmp_hi));

   // Load bookkeeping
   assign full        = (count_ff >= CNT_W'(MAX_ELEMS));
   assign total_new   = full ? count_ff : count_ff + CNT_W'(1);
   assign left_x      = LEN_X_W'(left_len_ff);
   assign total_x     = LEN_X_W'(total_new);
   assign count_x     = LEN_X_W'(count_ff);
   assign split_new   = (left_x < total_x) ? CNT_W'(left_x) : total_new;
   assign step_broken = !full && (count_ff != '0) && (count_x != left_x) && !cmp_le;
   assign over_new    = over_ff || full;
   assign broken_new  = broken_ff || step_broken;

   // Merge pick: left head while it lasts and the right run is used up or it is not above the right head
   assign take_left = (i_ff < split_ff) && ((j_ff >= total_ff) || cmp_le);
   assign i_step    = take_left ? i_ff + CNT_W'(1) : i_ff;
   assign j_step    = take_left ? j_ff : j_ff + CNT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_xfer && req_last_in) begin
               state_in = (over_new || broken_new) ? S_SEND : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_xfer) begin
               state_in = rsp_last_ff ? S_LOAD : S_CMP;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Datapath and output register
   always_comb begin
      left_len_in   = csr_valid ? csr_left_len : left_len_ff;
      count_in      = count_ff;
      prev_in       = prev_ff;
      broken_in     = broken_ff;
      over_in       = over_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      split_in      = split_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               if (!req_last_in) begin
                  // Advance the list
                  count_in  = total_new;
                  prev_in   = full ? prev_ff : req_value;
                  broken_in = broken_new;
                  over_in   = over_new;
               end else begin
                  // Close the list and set up the merge or status result
                  count_in  = '0;
                  prev_in   = '0;
                  broken_in = 1'b0;
                  over_in   = 1'b0;
                  i_in      = '0;
                  j_in      = split_new;
                  split_in  = split_new;
                  total_in  = total_new;
                  if (over_new || broken_new) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = over_new ? STATUS_OVERFLOW : STATUS_NOT_SORTED;
                     rsp_last_in   = 1'b1;
                  end
               end
            end
         end
         S_CMP: begin
            // Emit the smaller head and advance its run
            i_in          = i_step;
            j_in          = j_step;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = take_left ? rd_a : rd_b;
            rsp_status_in = STATUS_MERGED;
            rsp_last_in   = (i_step == split_ff) && (j_step == total_ff);
         end
         S_SEND: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         left_len_ff  <= LEFT_LEN_RESET;
         count_ff     <= '0;
         prev_ff      <= '0;
         broken_ff    <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_len_ff  <= left_len_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         broken_ff    <= broken_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Merge indexes and result payload
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      split_ff      <= split_in;
      total_ff      <= total_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sv/shm_checker.sv -----
// Port-level checks of the merge block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_halves_merge_top_macros.svh"

module shm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic signed [shm_pkg::DATA_W-1:0]    rsp_merged_value,
   input wire logic        [shm_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic                                 rsp_last_out
);

   import shm_pkg::*;

   // A stalled result holds its payload
   `SHM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_merged_value) && $stable(rsp_status) && $stable(rsp_last_out))

   // No element is taken while a result waits
   `SHM_ASSERT_NOW(a_busy_on_rsp, rsp_valid, req_stall)

   // A status result is final and carries a zero value
   `SHM_ASSERT_NOW(a_status_final, rsp_valid && (rsp_status != STATUS_MERGED), rsp_last_out && (rsp_merged_value == '0))

   // After the final transfer the block is ready for a new list
   `SHM_ASSERT_NEXT(a_ready_after_last, rsp_valid && !rsp_stall && rsp_last_out, !req_stall && !rsp_valid)

endmodule

bind sorted_halves_merge_top shm_checker u_shm_checker (.*);

`default_nettype wire
